// ----- rtl/world_to_screen_projection_unit_defines.svh -----
// assertion macros used by the checker file
`ifndef WORLD_TO_SCREEN_PROJECTION_UNIT_DEFINES_SVH
`define WORLD_TO_SCREEN_PROJECTION_UNIT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define WSP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, not disabled by reset
`define WSP_ASSERT_NEXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/wsp_pkg.sv -----
// shared constants and types for the projection unit
package wsp_pkg;

    localparam int NDC_BITS = 47;
    localparam int CFG_IDX_W = 4;
    localparam int SCREEN_W = 14;
    localparam int IN_DATA_W = 96;
    localparam int OUT_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_X_AB = 4'd0,
        CFG_ROW_X_CD = 4'd1,
        CFG_ROW_Y_AB = 4'd2,
        CFG_ROW_Y_CD = 4'd3,
        CFG_ROW_W_AB = 4'd4,
        CFG_ROW_W_CD = 4'd5,
        CFG_WIDTH    = 4'd6,
        CFG_HEIGHT   = 4'd7
    } t_cfg_idx;

endpackage

// ----- rtl/world_to_screen_projection_unit.sv -----
// world to screen projection unit: matrix rows, perspective divide, viewport map
// Projects one world point per beat onto the screen.
// Slave channel: i_s_tdata holds point_x, point_y, point_z (32 bits each, low first).
// Master channel: o_m_tdata holds pixel_x then pixel_y, o_m_tuser holds visible.
// Config channel: i_cfg_index selects the register, i_cfg_data carries the value;
// writes are always taken (o_cfg_ready is high) and are to be issued only while idle.
// Stages in order: input register, products, row sums, clip test and dividend
// setup, the divider, viewport multiply, and finally offset and saturation.
// Throughput is one point per cycle while the receiver does not stall; the
// divider has one stage per quotient bit, so every stage holds a different point.
// Synchronous active-low reset clears all valid bits and loads the default
// matrix (all zero) and the 1920x1080 viewport.
// When the receiver stalls with a result pending, the whole pipeline holds and
// o_s_tready drops; nothing is lost or repeated.
module world_to_screen_projection_unit #(
    parameter int FRAC_BITS   = 16,
    parameter int COORD_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [wsp_pkg::IN_DATA_W-1:0]     i_s_tdata,   // point_x, point_y, point_z
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [wsp_pkg::OUT_DATA_W-1:0]    o_m_tdata,   // pixel_x, pixel_y
    output logic                              o_m_tuser,   // visible
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [wsp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [63:0]                       i_cfg_data
);
    import wsp_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int FB = FRAC_BITS;
    localparam int PW = 2 * CW;
    localparam int SW = 2 * CW + 3;
    localparam int DW = SW + FB;
    localparam int QW = NDC_BITS;
    localparam int XW = DW + QW + 1;
    localparam int NW = QW + 1;
    localparam int MW = NW + SCREEN_W + 1;
    localparam int WMIN = ((1 << FB) + 5) / 10;
    localparam logic [QW-1:0] NDC_LIM = QW'(1) << (QW - 1);
    localparam logic signed [MW:0] SAT_HI = (MW+1)'((64'sd1 <<< (CW - 1)) - 64'sd1);
    localparam logic signed [MW:0] SAT_LO = -SAT_HI - (MW+1)'(1);

    // configuration
    logic [63:0]         r_mat [6];
    logic [SCREEN_W-1:0] r_width;
    logic [SCREEN_W-1:0] r_height;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) r_mat[i] <= '0;
            r_width  <= SCREEN_W'(1920);
            r_height <= SCREEN_W'(1080);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_ROW_X_AB: r_mat[0] <= i_cfg_data;
                CFG_ROW_X_CD: r_mat[1] <= i_cfg_data;
                CFG_ROW_Y_AB: r_mat[2] <= i_cfg_data;
                CFG_ROW_Y_CD: r_mat[3] <= i_cfg_data;
                CFG_ROW_W_AB: r_mat[4] <= i_cfg_data;
                CFG_ROW_W_CD: r_mat[5] <= i_cfg_data;
                CFG_WIDTH:    r_width  <= i_cfg_data[SCREEN_W-1:0];
                CFG_HEIGHT:   r_height <= i_cfg_data[SCREEN_W-1:0];
                default: ;
            endcase
        end
    end

    logic signed [CW-1:0] w_coef [3][3];
    logic signed [CW-1:0] w_kc   [3];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            w_coef[r][0] = r_mat[2*r][CW-1:0];
            w_coef[r][1] = r_mat[2*r][32 +: CW];
            w_coef[r][2] = r_mat[2*r+1][CW-1:0];
            w_kc[r]      = r_mat[2*r+1][32 +: CW];
        end
    end

    // pipeline advance
    logic r_out_valid;
    logic w_en;

    assign w_en       = !r_out_valid || i_m_tready;
    assign o_s_tready = w_en;

    // stage 1: input register
    logic                 r1_v;
    logic signed [CW-1:0] r1_p [3];

    // stage 2: products
    logic                 r2_v;
    logic signed [PW-1:0] r2_prod [3][3];

    // stage 3: row sums
    logic                 r3_v;
    logic signed [SW-1:0] r3_sum [3];

    // stage 4: clip test and dividends
    logic          r4_v;
    logic          r4_vis;
    logic [SW-1:0] r4_den;
    logic [DW-1:0] r4_nx;
    logic [DW-1:0] r4_ny;
    logic          r4_negx;
    logic          r4_negy;
    logic          r4_ovfx;
    logic          r4_ovfy;

    logic          w_vis;
    logic [SW-1:0] w_magx;
    logic [SW-1:0] w_magy;
    logic [DW-1:0] w_dx;
    logic [DW-1:0] w_dy;
    logic [XW-1:0] w_lim;

    assign w_vis  = r3_sum[2] >= ((SW)'(WMIN) <<< FB);
    assign w_magx = r3_sum[0][SW-1] ? SW'(-r3_sum[0]) : SW'(r3_sum[0]);
    assign w_magy = r3_sum[1][SW-1] ? SW'(-r3_sum[1]) : SW'(r3_sum[1]);
    assign w_dx   = DW'(w_magx) << FB;
    assign w_dy   = DW'(w_magy) << FB;
    assign w_lim  = XW'(r3_sum[2][SW-1:0]) << QW;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= i_s_tvalid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < 3; c++) r1_p[c] <= i_s_tdata[32*c +: CW];
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r2_prod[r][c] <= PW'(r1_p[c]) * PW'(w_coef[r][c]);
                end
            end
            for (int r = 0; r < 3; r++) begin
                r3_sum[r] <= SW'(r2_prod[r][0]) + SW'(r2_prod[r][1]) + SW'(r2_prod[r][2])
                           + (SW'(w_kc[r]) <<< FB);
            end
            r4_vis  <= w_vis;
            r4_den  <= r3_sum[2][SW-1:0];
            r4_nx   <= w_dx;
            r4_ny   <= w_dy;
            r4_negx <= r3_sum[0][SW-1];
            r4_negy <= r3_sum[1][SW-1];
            r4_ovfx <= XW'(w_dx) >= w_lim;
            r4_ovfy <= XW'(w_dy) >= w_lim;
        end
    end

    // divider
    logic          d_v;
    logic          d_vis;
    logic [QW-1:0] d_qx;
    logic [QW-1:0] d_qy;
    logic          d_negx;
    logic          d_negy;
    logic          d_ovfx;
    logic          d_ovfy;

    wsp_ndc_div #(
        .DW (DW),
        .SW (SW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r4_v),
        .i_vis   (r4_vis),
        .i_den   (r4_den),
        .i_num_x (r4_nx),
        .i_num_y (r4_ny),
        .i_neg_x (r4_negx),
        .i_neg_y (r4_negy),
        .i_ovf_x (r4_ovfx),
        .i_ovf_y (r4_ovfy),
        .o_valid (d_v),
        .o_vis   (d_vis),
        .o_q_x   (d_qx),
        .o_q_y   (d_qy),
        .o_neg_x (d_negx),
        .o_neg_y (d_negy),
        .o_ovf_x (d_ovfx),
        .o_ovf_y (d_ovfy)
    );

    // stage 5: viewport scale
    logic [QW-1:0]        w_mx;
    logic [QW-1:0]        w_my;
    logic signed [NW-1:0] w_ndx;
    logic signed [NW-1:0] w_ndy;
    logic signed [SCREEN_W:0] w_wd;
    logic signed [SCREEN_W:0] w_hh;

    assign w_mx  = (d_ovfx || d_qx > NDC_LIM) ? NDC_LIM : d_qx;
    assign w_my  = (d_ovfy || d_qy > NDC_LIM) ? NDC_LIM : d_qy;
    assign w_ndx = d_negx ? -$signed({1'b0, w_mx}) : $signed({1'b0, w_mx});
    assign w_ndy = d_negy ? -$signed({1'b0, w_my}) : $signed({1'b0, w_my});
    assign w_wd  = $signed({1'b0, r_width});
    assign w_hh  = $signed({2'b00, r_height[SCREEN_W-1:1]});

    logic                 r5_v;
    logic                 r5_vis;
    logic signed [MW-1:0] r5_px;
    logic signed [MW-1:0] r5_py;

    // stage 6: offset, saturate
    logic signed [MW:0] w_sx;
    logic signed [MW:0] w_sy;
    logic signed [MW:0] w_ox;
    logic signed [MW:0] w_oy;
    logic signed [CW-1:0] w_fx;
    logic signed [CW-1:0] w_fy;

    assign w_ox = (MW+1)'(w_wd) <<< FB;
    assign w_oy = (MW+1)'(w_hh) <<< FB;
    assign w_sx = ((MW+1)'(r5_px) + w_ox) >>> 1;
    assign w_sy = w_oy - (MW+1)'(r5_py);
    assign w_fx = (w_sx > SAT_HI) ? CW'(SAT_HI) : (w_sx < SAT_LO) ? CW'(SAT_LO) : CW'(w_sx);
    assign w_fy = (w_sy > SAT_HI) ? CW'(SAT_HI) : (w_sy < SAT_LO) ? CW'(SAT_LO) : CW'(w_sy);

    logic               r_vis_out;
    logic signed [31:0] r_pix_x;
    logic signed [31:0] r_pix_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r5_v        <= d_v;
            r_out_valid <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_vis    <= d_vis;
            r5_px     <= MW'(w_ndx) * MW'(w_wd);
            r5_py     <= MW'(w_ndy) * MW'(w_hh);
            r_vis_out <= r5_vis;
            r_pix_x   <= r5_vis ? 32'(w_fx) : '0;
            r_pix_y   <= r5_vis ? 32'(w_fy) : '0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_vis_out;
    assign o_m_tdata  = {r_pix_y, r_pix_x};

endmodule

// ----- rtl/wsp_ndc_div.sv -----
// pipelined restoring divider, one quotient bit per stage, x and y share the divisor
module wsp_ndc_div #(
    parameter int DW = 82,
    parameter int SW = 67
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic                          i_vis,
    input  logic [SW-1:0]                 i_den,
    input  logic [DW-1:0]                 i_num_x,
    input  logic [DW-1:0]                 i_num_y,
    input  logic                          i_neg_x,
    input  logic                          i_neg_y,
    input  logic                          i_ovf_x,
    input  logic                          i_ovf_y,
    output logic                          o_valid,
    output logic                          o_vis,
    output logic [wsp_pkg::NDC_BITS-1:0]  o_q_x,
    output logic [wsp_pkg::NDC_BITS-1:0]  o_q_y,
    output logic                          o_neg_x,
    output logic                          o_neg_y,
    output logic                          o_ovf_x,
    output logic                          o_ovf_y
);
    import wsp_pkg::*;

    localparam int QW = NDC_BITS;
    localparam int XW = DW + QW;

    logic          r_v   [QW+1];
    logic          r_vis [QW+1];
    logic [SW-1:0] r_den [QW+1];
    logic [DW-1:0] r_rx  [QW+1];
    logic [DW-1:0] r_ry  [QW+1];
    logic [QW-1:0] r_qx  [QW+1];
    logic [QW-1:0] r_qy  [QW+1];
    logic          r_nx  [QW+1];
    logic          r_ny  [QW+1];
    logic          r_ox  [QW+1];
    logic          r_oy  [QW+1];

    assign r_v[0]   = i_valid;
    assign r_vis[0] = i_vis;
    assign r_den[0] = i_den;
    assign r_rx[0]  = i_num_x;
    assign r_ry[0]  = i_num_y;
    assign r_qx[0]  = '0;
    assign r_qy[0]  = '0;
    assign r_nx[0]  = i_neg_x;
    assign r_ny[0]  = i_neg_y;
    assign r_ox[0]  = i_ovf_x;
    assign r_oy[0]  = i_ovf_y;

    for (genvar j = 0; j < QW; j++) begin : g_stage
        logic [XW-1:0] w_sub;
        logic          w_gex;
        logic          w_gey;

        assign w_sub = XW'(r_den[j]) << (QW - 1 - j);
        assign w_gex = XW'(r_rx[j]) >= w_sub;
        assign w_gey = XW'(r_ry[j]) >= w_sub;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j+1] <= 1'b0;
            end else if (i_en) begin
                r_v[j+1] <= r_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_vis[j+1] <= r_vis[j];
                r_den[j+1] <= r_den[j];
                r_rx[j+1]  <= w_gex ? r_rx[j] - w_sub[DW-1:0] : r_rx[j];
                r_ry[j+1]  <= w_gey ? r_ry[j] - w_sub[DW-1:0] : r_ry[j];
                r_qx[j+1]  <= {r_qx[j][QW-2:0], w_gex};
                r_qy[j+1]  <= {r_qy[j][QW-2:0], w_gey};
                r_nx[j+1]  <= r_nx[j];
                r_ny[j+1]  <= r_ny[j];
                r_ox[j+1]  <= r_ox[j];
                r_oy[j+1]  <= r_oy[j];
            end
        end
    end

    assign o_valid = r_v[QW];
    assign o_vis   = r_vis[QW];
    assign o_q_x   = r_qx[QW];
    assign o_q_y   = r_qy[QW];
    assign o_neg_x = r_nx[QW];
    assign o_neg_y = r_ny[QW];
    assign o_ovf_x = r_ox[QW];
    assign o_ovf_y = r_oy[QW];

endmodule

// ----- rtl/wsp_checker.sv -----
// port-level checker for the projection unit, with its bind
`include "world_to_screen_projection_unit_defines.svh"

module wsp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [63:0] o_m_tdata,
    input logic        o_m_tuser
);

    `WSP_ASSERT_IMPLY(a_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, ##1 (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser)), "stalled beat changed")
    `WSP_ASSERT_IMPLY(a_hidden_zero, i_clk, i_rst_n, o_m_tvalid && !o_m_tuser, o_m_tdata == 64'd0, "hidden point has nonzero pixels")
    `WSP_ASSERT_IMPLY(a_ready, i_clk, i_rst_n, 1'b1, o_s_tready == (!o_m_tvalid || i_m_tready), "input ready does not follow output stall")
    `WSP_ASSERT_NEXT(a_reset, i_clk, !i_rst_n, !o_m_tvalid, "output valid after reset")

endmodule

bind world_to_screen_projection_unit wsp_checker u_wsp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
